>>> rtl/core/atp_pkg.sv
// shared types, constants and helpers for the activation threshold pack unit
package atp_pkg;

  localparam int unsigned MaxRowLenDefault = 65536;
  localparam int unsigned MaxRowsDefault   = 65536;
  localparam int unsigned CfgIndexWidth    = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SHARED_THRESHOLD  = 2'd0,
    REG_PER_ROW_MODE      = 2'd1,
    REG_INCLUSIVE_COMPARE = 2'd2,
    REG_ELEMENT_FORMAT    = 2'd3
  } cfg_reg_t;

  localparam logic FMT_HALF     = 1'b0;
  localparam logic FMT_BFLOAT16 = 1'b1;

  typedef struct packed {
    logic [15:0] element_bits;
    logic [31:0] row_threshold;
    logic        last_in_row;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [15:0] kept_value;
    logic [15:0] kept_index;
    logic        row_done;
    logic [16:0] kept_count;
    logic [15:0] row_number;
  } out_item_t;

  // classified element handed from front to back
  typedef struct packed {
    logic        keep;
    logic        last;
    logic [15:0] bits;
    logic [15:0] column;
    logic [15:0] row;
  } cls_item_t;

  // exact fp32 bit pattern of |element|
  function automatic logic [30:0] widen_magnitude(input logic [15:0] bits, input logic fmt);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [9:0]  ms;
    logic [30:0] r;
    e  = bits[14:10];
    m  = bits[9:0];
    lz = 4'd0;
    ms = '0;
    r  = '0;
    if (fmt == FMT_BFLOAT16) begin
      r = {bits[14:0], 16'h0000};
    end else if (e == 5'h1f) begin
      r = {8'hff, m, 13'h0};
    end else if (e != 5'd0) begin
      r = {(8'(e) + 8'd112), m, 13'h0};
    end else if (m != 10'd0) begin
      for (int i = 0; i < 10; i++) begin
        if (m[i]) lz = 4'(9 - i);
      end
      ms = 10'(m << (lz + 4'd1));
      r  = {(8'd113 - 8'd1 - 8'(lz)), ms, 13'h0};
    end
    return r;
  endfunction

  function automatic logic passes(input logic [30:0] mag, input logic [31:0] thr,
                                  input logic incl);
    logic [30:0] tabs;
    logic        res;
    tabs = thr[30:0];
    if (mag > 31'h7f800000 || tabs > 31'h7f800000) begin
      res = 1'b0;
    end else if (thr[31] && tabs != 31'd0) begin
      res = 1'b1;
    end else if (thr[31]) begin
      res = incl ? 1'b1 : (mag > 31'd0);
    end else begin
      res = incl ? (mag >= tabs) : (mag > tabs);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/activation_threshold_pack_unit.sv
// top level of the activation threshold pack unit
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | element_bits, row_threshold, last_in_row
//   out     | output    | out_valid / out_ready | entry_valid .. row_number
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one element per cycle sustained while out_ready stays high; a result passes through the
// front classify, the queue and the registered back stage
// rst clears counters, registers and the queue; cfg_ready is always high
// an output stall fills the two-entry queue, then in_ready drops
module activation_threshold_pack_unit #(
  parameter int unsigned MAX_ROW_LEN = atp_pkg::MaxRowLenDefault,
  parameter int unsigned MAX_ROWS    = atp_pkg::MaxRowsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  atp_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output atp_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [atp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic [31:0] shared_threshold;
  logic        per_row_mode;
  logic        inclusive_compare;
  logic        element_format;

  logic               f_valid, f_ready, b_valid, b_ready;
  atp_pkg::cls_item_t f_data, b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_threshold  <= '0;
      per_row_mode      <= 1'b0;
      inclusive_compare <= 1'b0;
      element_format    <= atp_pkg::FMT_HALF;
    end else if (cfg_valid) begin
      unique case (atp_pkg::cfg_reg_t'(cfg_index))
        atp_pkg::REG_SHARED_THRESHOLD:  shared_threshold  <= cfg_data;
        atp_pkg::REG_PER_ROW_MODE:      per_row_mode      <= cfg_data[0];
        atp_pkg::REG_INCLUSIVE_COMPARE: inclusive_compare <= cfg_data[0];
        atp_pkg::REG_ELEMENT_FORMAT:    element_format    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  atp_front #(.MAX_ROW_LEN(MAX_ROW_LEN), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .shared_threshold, .per_row_mode, .inclusive_compare, .element_format,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
  );

  atp_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  atp_back #(.MAX_ROW_LEN(MAX_ROW_LEN)) u_back (
    .clk, .rst,
    .cls_valid(b_valid), .cls_ready(b_ready), .cls_data(b_data),
    .out_valid, .out_ready, .out_data
  );

endmodule

>>> rtl/core/atp_front.sv
// front end: accepts elements, tracks row position and classifies each element
module atp_front #(
  parameter int unsigned MAX_ROW_LEN = atp_pkg::MaxRowLenDefault,
  parameter int unsigned MAX_ROWS    = atp_pkg::MaxRowsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  atp_pkg::in_item_t  in_data,
  input  logic [31:0]        shared_threshold,
  input  logic               per_row_mode,
  input  logic               inclusive_compare,
  input  logic               element_format,
  output logic               cls_valid,
  input  logic               cls_ready,
  output atp_pkg::cls_item_t cls_data
);

  logic [15:0] column_counter;
  logic [15:0] row_counter;
  logic [31:0] latched_threshold;
  logic        at_row_start;
  logic [31:0] thr;
  logic        fire;

  assign in_ready = cls_ready;
  assign cls_valid = in_valid;
  assign fire = in_valid && cls_ready;

  always_comb begin
    if (per_row_mode) begin
      thr = at_row_start ? in_data.row_threshold : latched_threshold;
    end else begin
      thr = shared_threshold;
    end
  end

  assign cls_data.keep = atp_pkg::passes(
      atp_pkg::widen_magnitude(in_data.element_bits, element_format), thr, inclusive_compare);
  assign cls_data.last   = in_data.last_in_row;
  assign cls_data.bits   = in_data.element_bits;
  assign cls_data.column = column_counter;
  assign cls_data.row    = row_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter    <= '0;
      row_counter       <= '0;
      latched_threshold <= '0;
      at_row_start      <= 1'b1;
    end else if (fire) begin
      if (at_row_start) latched_threshold <= in_data.row_threshold;
      if (in_data.last_in_row) begin
        column_counter <= '0;
        at_row_start   <= 1'b1;
        if (17'(row_counter) < 17'(MAX_ROWS - 1)) row_counter <= row_counter + 16'd1;
      end else begin
        at_row_start <= 1'b0;
        if (17'(column_counter) < 17'(MAX_ROW_LEN - 1))
          column_counter <= column_counter + 16'd1;
      end
    end
  end

endmodule

>>> rtl/core/atp_queue.sv
// two-entry queue between front and back
module atp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  atp_pkg::cls_item_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output atp_pkg::cls_item_t rd_data
);

  atp_pkg::cls_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data  = slot[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) slot[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

>>> rtl/core/atp_back.sv
// back end: counts kept elements, drops silent items and forms results
module atp_back #(
  parameter int unsigned MAX_ROW_LEN = atp_pkg::MaxRowLenDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cls_valid,
  output logic               cls_ready,
  input  atp_pkg::cls_item_t cls_data,
  output logic               out_valid,
  input  logic               out_ready,
  output atp_pkg::out_item_t out_data
);

  logic [16:0] kept_counter;
  logic [16:0] kept_next;
  logic        emit;
  logic        take;
  atp_pkg::out_item_t res;

  assign emit      = cls_data.keep || cls_data.last;
  assign cls_ready = !out_valid || out_ready;
  assign take      = cls_valid && cls_ready;

  always_comb begin
    kept_next = kept_counter;
    if (cls_data.keep && kept_counter < 17'(MAX_ROW_LEN)) kept_next = kept_counter + 17'd1;
    res.entry_valid = cls_data.keep;
    res.kept_value  = cls_data.keep ? cls_data.bits : 16'd0;
    res.kept_index  = cls_data.keep ? cls_data.column : 16'd0;
    res.row_done    = cls_data.last;
    res.kept_count  = cls_data.last ? kept_next : 17'd0;
    res.row_number  = cls_data.row;
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        kept_counter <= cls_data.last ? 17'd0 : kept_next;
        out_valid    <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/atp_checker.sv
// port-level checks for the activation threshold pack unit
module atp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input atp_pkg::out_item_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transfer withdrawn while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transfer dropped while stalled");

  a_has_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_valid || out_data.row_done)
    else $error("result with neither kept entry nor row end");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.row_done |-> out_data.kept_count == 17'd0)
    else $error("kept count outside row end");

  a_no_spawn: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind activation_threshold_pack_unit atp_checker u_atp_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
